>>> rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is held.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: assertion failed");

`endif

>>> rtl/psbs_pkg.sv
`default_nettype none
package psbs_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int P_W    = 16;  // port position / velocity width
  localparam int DT_W   = 16;
  localparam int P1_W   = 18;  // moved position, unsaturated
  localparam int V1_W   = 19;  // pulled velocity, unsaturated
  localparam int MAG2_W = 38;  // squared length
  localparam int MAG_W  = 19;  // integer square root
  localparam int LIM_W  = 15;
  localparam int Q_W    = 15;  // rescaled component magnitude
  localparam int NUM_W  = MAG_W + Q_W;
  localparam int CFG_ADDR_W = 4;

  localparam logic [15:0] GAIN_RESET = 16'd6554;

  localparam logic [1:0] REG_GAIN  = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_WALL  = 2'd2;

  typedef struct packed {
    logic [15:0]          gain;
    logic [LIM_W-1:0]     lim;
    logic [2*LIM_W-1:0]   lim_sq;
    logic [LIM_W-1:0]     wb;
  } psbs_cfg_t;

  typedef struct packed {
    logic [2:0][P1_W-1:0] p1;
    logic [2:0][V1_W-1:0] v1;
    logic                 over;
  } psbs_body_t;

endpackage
`default_nettype wire

>>> rtl/psbs_euler.sv
`default_nettype none
module psbs_euler (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire psbs_pkg::psbs_cfg_t       cfg,
  input  wire logic                      in_vld,
  input  wire logic [2:0][15:0]          in_pos,
  input  wire logic [2:0][15:0]          in_vel,
  input  wire logic [15:0]               in_dt,
  output logic                           out_vld,
  output psbs_pkg::psbs_body_t           out_body,
  output logic [psbs_pkg::MAG2_W-1:0]    out_mag2
);

  logic [5:0] vld_r;

  logic [2:0][15:0] pos1_r, vel1_r, vel2_r, vel3_r;
  logic [2:0][32:0] vdt1_r;
  logic [31:0]      gd1_r, gd2_r;
  logic [2:0][psbs_pkg::P1_W-1:0] p1_2_r, p1_3_r, p1_4_r, p1_5_r;
  logic [2:0][50:0] pq3_r;
  logic [2:0][psbs_pkg::V1_W-1:0] v1_4_r, v1_5_r;
  logic [2:0][psbs_pkg::MAG2_W-1:0] sq5_r;
  psbs_pkg::psbs_body_t body6_r;
  logic [psbs_pkg::MAG2_W-1:0] mag2_6_r;

  logic [2:0][32:0] vdt1_nxt;
  logic [31:0]      gd1_nxt;
  logic [2:0][psbs_pkg::P1_W-1:0] p1_2_nxt;
  logic [2:0][50:0] pq3_nxt;
  logic [2:0][psbs_pkg::V1_W-1:0] v1_4_nxt;
  logic [2:0][psbs_pkg::MAG2_W-1:0] sq5_nxt;
  logic [psbs_pkg::MAG2_W-1:0] mag2_6_nxt;
  logic [33:0] rnd_v;
  logic [51:0] rnd_q;
  logic signed [19:0] v1_w;
  logic signed [37:0] sq_w;

  always_comb begin
    gd1_nxt = 32'(cfg.gain) * 32'(in_dt);
    for (int i = 0; i < 3; i++) begin
      vdt1_nxt[i] = 33'($signed(in_vel[i]) * $signed({1'b0, in_dt}));
    end
  end

  // round to nearest, ties up: add half then floor-shift
  always_comb begin
    rnd_v = '0;
    rnd_q = '0;
    v1_w  = '0;
    sq_w  = '0;
    for (int i = 0; i < 3; i++) begin
      rnd_v       = 34'($signed(vdt1_r[i])) + 34'sd32768;
      p1_2_nxt[i] = psbs_pkg::P1_W'($signed(pos1_r[i])) + $signed(rnd_v[33:16]);
      pq3_nxt[i]  = 51'($signed({1'b0, gd2_r}) * $signed(p1_2_r[i]));
      rnd_q       = 52'($signed(pq3_r[i])) + (52'sd1 <<< 31);
      v1_w        = 20'($signed(vel3_r[i])) - $signed(rnd_q[51:32]);
      v1_4_nxt[i] = v1_w[psbs_pkg::V1_W-1:0];
      sq_w        = 38'($signed(v1_4_r[i]) * $signed(v1_4_r[i]));
      sq5_nxt[i]  = sq_w;
    end
    mag2_6_nxt = sq5_r[0] + sq5_r[1] + sq5_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos1_r   <= in_pos;
      vel1_r   <= in_vel;
      vdt1_r   <= vdt1_nxt;
      gd1_r    <= gd1_nxt;
      p1_2_r   <= p1_2_nxt;
      vel2_r   <= vel1_r;
      gd2_r    <= gd1_r;
      pq3_r    <= pq3_nxt;
      p1_3_r   <= p1_2_r;
      vel3_r   <= vel2_r;
      v1_4_r   <= v1_4_nxt;
      p1_4_r   <= p1_3_r;
      sq5_r    <= sq5_nxt;
      v1_5_r   <= v1_4_r;
      p1_5_r   <= p1_4_r;
      mag2_6_r     <= mag2_6_nxt;
      body6_r.p1   <= p1_5_r;
      body6_r.v1   <= v1_5_r;
      body6_r.over <= mag2_6_nxt > psbs_pkg::MAG2_W'(cfg.lim_sq);
    end
  end

  assign out_vld  = vld_r[5];
  assign out_body = body6_r;
  assign out_mag2 = mag2_6_r;

endmodule
`default_nettype wire

>>> rtl/psbs_isqrt.sv
`default_nettype none
module psbs_isqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_vld,
  input  wire psbs_pkg::psbs_body_t      in_body,
  input  wire logic [psbs_pkg::MAG2_W-1:0] in_mag2,
  output logic                           out_vld,
  output psbs_pkg::psbs_body_t           out_body,
  output logic [psbs_pkg::MAG_W-1:0]     out_mag
);

  localparam int N     = psbs_pkg::MAG_W;
  localparam int REM_W = psbs_pkg::MAG_W + 2;

  logic [N:0]                       vld_r;
  psbs_pkg::psbs_body_t             body_r [N+1];
  logic [psbs_pkg::MAG2_W-1:0]      n_r    [N+1];
  logic [psbs_pkg::MAG_W-1:0]       root_r [N+1];
  logic [REM_W-1:0]                 rem_r  [N+1];

  logic [psbs_pkg::MAG2_W-1:0]      n_nxt    [1:N];
  logic [psbs_pkg::MAG_W-1:0]       root_nxt [1:N];
  logic [REM_W-1:0]                 rem_nxt  [1:N];
  logic [REM_W+1:0]                 rem_sh, trial;

  // one result bit per stage, two radicand bits consumed
  always_comb begin
    rem_sh = '0;
    trial  = '0;
    for (int s = 1; s <= N; s++) begin
      rem_sh   = {rem_r[s-1], n_r[s-1][psbs_pkg::MAG2_W-1 -: 2]};
      trial    = {2'b00, root_r[s-1], 2'b01};
      n_nxt[s] = n_r[s-1] << 2;
      if (rem_sh >= trial) begin
        rem_nxt[s]  = REM_W'(rem_sh - trial);
        root_nxt[s] = {root_r[s-1][psbs_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt[s]  = rem_sh[REM_W-1:0];
        root_nxt[s] = {root_r[s-1][psbs_pkg::MAG_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      body_r[0] <= in_body;
      n_r[0]    <= in_mag2;
      root_r[0] <= '0;
      rem_r[0]  <= '0;
      for (int s = 1; s <= N; s++) begin
        body_r[s] <= body_r[s-1];
        n_r[s]    <= n_nxt[s];
        root_r[s] <= root_nxt[s];
        rem_r[s]  <= rem_nxt[s];
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign out_body = body_r[N];
  assign out_mag  = root_r[N];

endmodule
`default_nettype wire

>>> rtl/psbs_div.sv
`default_nettype none
module psbs_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic [psbs_pkg::LIM_W-1:0]  lim,
  input  wire logic                        in_vld,
  input  wire psbs_pkg::psbs_body_t        in_body,
  input  wire logic [psbs_pkg::MAG_W-1:0]  in_mag,
  output logic                             out_vld,
  output psbs_pkg::psbs_body_t             out_body,
  output logic [2:0][psbs_pkg::Q_W-1:0]    out_quo
);

  localparam int N  = psbs_pkg::Q_W;
  localparam int NW = psbs_pkg::NUM_W;

  logic [N:0]                        vld_r;
  psbs_pkg::psbs_body_t              body_r [N+1];
  logic [psbs_pkg::MAG_W-1:0]        mag_r  [N+1];
  logic [2:0][NW-1:0]                rem_r  [N+1];
  logic [2:0][psbs_pkg::Q_W-1:0]     quo_r  [N+1];

  logic [2:0][NW-1:0]                num_nxt;
  logic [2:0][NW-1:0]                rem_nxt [1:N];
  logic [2:0][psbs_pkg::Q_W-1:0]     quo_nxt [1:N];
  logic [psbs_pkg::MAG_W-1:0]        mag_abs;
  logic [NW-1:0]                     dvs;

  // magnitude times limit; the sign is restored after the divide
  always_comb begin
    mag_abs = '0;
    for (int i = 0; i < 3; i++) begin
      mag_abs    = in_body.v1[i][psbs_pkg::V1_W-1] ? psbs_pkg::MAG_W'(-in_body.v1[i])
                                                   : in_body.v1[i];
      num_nxt[i] = NW'(mag_abs) * NW'(lim);
    end
  end

  // restoring divide, quotient MSB first
  always_comb begin
    dvs = '0;
    for (int s = 1; s <= N; s++) begin
      dvs = NW'(mag_r[s-1]) << (N - s);
      for (int i = 0; i < 3; i++) begin
        if (rem_r[s-1][i] >= dvs) begin
          rem_nxt[s][i] = rem_r[s-1][i] - dvs;
          quo_nxt[s][i] = {quo_r[s-1][i][psbs_pkg::Q_W-2:0], 1'b1};
        end else begin
          rem_nxt[s][i] = rem_r[s-1][i];
          quo_nxt[s][i] = {quo_r[s-1][i][psbs_pkg::Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      body_r[0] <= in_body;
      mag_r[0]  <= in_mag;
      rem_r[0]  <= num_nxt;
      quo_r[0]  <= '0;
      for (int s = 1; s <= N; s++) begin
        body_r[s] <= body_r[s-1];
        mag_r[s]  <= mag_r[s-1];
        rem_r[s]  <= rem_nxt[s];
        quo_r[s]  <= quo_nxt[s];
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign out_body = body_r[N];
  assign out_quo  = quo_r[N];

endmodule
`default_nettype wire

>>> rtl/particle_spring_bounce_step.sv
// Particle step: one semi-implicit Euler update of position and velocity per request,
// with spring pull toward the origin, speed limit and wall reflection.
// Input stream in_*: tdata carries pos x/y/z, vel x/y/z and time_step.
// Output stream out_*: tdata carries new pos, new vel, speed_clipped, wall_hits.
// Config (cfg_*, APB): 0x0 spring_gain, 0x4 speed_limit, 0x8 wall_bound.
// Write registers only while no request is in flight.
// Throughput: one request per cycle while the receiver does not stall. Stages:
// the 6-stage multiply path, the 20-stage
// square root (an input register, then one root bit per stage) and the
// 16-stage rescale divider (multiply plus one quotient bit per stage), then
// one clamp stage.
// Reset empties the pipeline and loads the default register values.
// When the receiver stalls, the last result moves into a skid register and
// the pipeline freezes; in_tready drops in the cycle after a stall begins and returns
// the cycle after the held result is taken. Nothing is dropped or repeated.
`default_nettype none
module particle_spring_bounce_step #(
  parameter int FRAC_BITS = psbs_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [63:48] vel_x, [79:64] vel_y,
  // [95:80] vel_z, [111:96] time_step
  input  wire logic [111:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [15:0] new_pos_x, [31:16] new_pos_y, [47:32] new_pos_z, [63:48] new_vel_x,
  // [79:64] new_vel_y, [95:80] new_vel_z, [96] speed_clipped, [99:97] wall_hits,
  // [103:100] zero
  output logic [103:0]      out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [psbs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam logic [psbs_pkg::LIM_W-1:0] LIM_RESET =
    (FRAC_BITS >= 15) ? 15'h7FFF : psbs_pkg::LIM_W'(1 << FRAC_BITS);
  localparam logic [psbs_pkg::LIM_W-1:0] WALL_RESET =
    (FRAC_BITS >= 16) ? 15'h7FFF : psbs_pkg::LIM_W'(1 << (FRAC_BITS - 1));

  logic [15:0]                 gain_r;
  logic [psbs_pkg::LIM_W-1:0]  lim_r, wb_r;
  logic [2*psbs_pkg::LIM_W-1:0] lim_sq_r;
  psbs_pkg::psbs_cfg_t         cfg;
  logic                        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= psbs_pkg::GAIN_RESET;
      lim_r    <= LIM_RESET;
      wb_r     <= WALL_RESET;
      lim_sq_r <= '0;
    end else begin
      lim_sq_r <= 30'(lim_r) * 30'(lim_r);
      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          psbs_pkg::REG_GAIN:  gain_r <= cfg_pwdata[15:0];
          psbs_pkg::REG_LIMIT: lim_r  <= cfg_pwdata[14:0];
          psbs_pkg::REG_WALL:  wb_r   <= cfg_pwdata[14:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      psbs_pkg::REG_GAIN:  cfg_prdata = {16'b0, gain_r};
      psbs_pkg::REG_LIMIT: cfg_prdata = {17'b0, lim_r};
      psbs_pkg::REG_WALL:  cfg_prdata = {17'b0, wb_r};
      default:             cfg_prdata = '0;
    endcase
  end

  assign cfg.gain   = gain_r;
  assign cfg.lim    = lim_r;
  assign cfg.lim_sq = lim_sq_r;
  assign cfg.wb     = wb_r;

  logic             en;
  logic             skid_v_r;
  logic [103:0]     skid_r;
  logic             res_v_r;
  logic [103:0]     res_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  logic [2:0][15:0] in_pos, in_vel;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_pos[i] = in_tdata[16*i +: 16];
      in_vel[i] = in_tdata[48 + 16*i +: 16];
    end
  end

  logic                          e_vld, s_vld, d_vld;
  psbs_pkg::psbs_body_t          e_body, s_body, d_body;
  logic [psbs_pkg::MAG2_W-1:0]   e_mag2;
  logic [psbs_pkg::MAG_W-1:0]    s_mag;
  logic [2:0][psbs_pkg::Q_W-1:0] d_quo;

  psbs_euler u_euler (
    .clk, .rst_n, .en, .cfg,
    .in_vld   (in_tvalid),
    .in_pos   (in_pos),
    .in_vel   (in_vel),
    .in_dt    (in_tdata[111:96]),
    .out_vld  (e_vld),
    .out_body (e_body),
    .out_mag2 (e_mag2)
  );

  psbs_isqrt u_isqrt (
    .clk, .rst_n, .en,
    .in_vld   (e_vld),
    .in_body  (e_body),
    .in_mag2  (e_mag2),
    .out_vld  (s_vld),
    .out_body (s_body),
    .out_mag  (s_mag)
  );

  psbs_div u_div (
    .clk, .rst_n, .en,
    .lim      (lim_r),
    .in_vld   (s_vld),
    .in_body  (s_body),
    .in_mag   (s_mag),
    .out_vld  (d_vld),
    .out_body (d_body),
    .out_quo  (d_quo)
  );

  // speed select, wall clamp and reflection
  logic [103:0]       res_nxt;
  logic signed [15:0] v2, vo;
  logic signed [17:0] wbs, po;
  logic [2:0]         hits;

  always_comb begin
    v2   = '0;
    vo   = '0;
    po   = '0;
    hits = '0;
    wbs  = $signed({3'b000, wb_r});
    res_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (d_body.over) begin
        v2 = d_body.v1[i][psbs_pkg::V1_W-1] ? -$signed({1'b0, d_quo[i]})
                                           :  $signed({1'b0, d_quo[i]});
      end else begin
        v2 = $signed(d_body.v1[i][15:0]);
      end
      if ($signed(d_body.p1[i]) < -wbs) begin
        po = -wbs;
        hits[i] = 1'b1;
      end else if ($signed(d_body.p1[i]) > wbs) begin
        po = wbs;
        hits[i] = 1'b1;
      end else begin
        po = $signed(d_body.p1[i]);
      end
      vo = hits[i] ? -v2 : v2;
      res_nxt[16*i +: 16]      = po[15:0];
      res_nxt[48 + 16*i +: 16] = vo;
    end
    res_nxt[96]    = d_body.over;
    res_nxt[99:97] = hits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) skid_v_r <= 1'b0;
    end else begin
      res_v_r <= d_vld;
      // hold a stalled result aside so the pipeline can advance once more
      if (res_v_r && !out_tready) skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      skid_r <= res_r;
    end
  end

  assign out_tvalid = skid_v_r || res_v_r;
  assign out_tdata  = skid_v_r ? skid_r : res_r;

endmodule
`default_nettype wire

>>> rtl/psbs_checker.sv
`default_nettype none
`include "assert_macros.svh"
module psbs_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [103:0] out_tdata
);

  `ASSERT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `ASSERT_RST(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata))
  `ASSERT_RST(a_ready_drop, clk, rst_n, !in_tready |-> $past(out_tvalid && !out_tready))
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid && in_tready)
  `ASSERT_RST(a_pad_zero, clk, rst_n, out_tvalid |-> out_tdata[103:100] == 4'b0000)

endmodule

bind particle_spring_bounce_step psbs_checker u_psbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
